>>> rtl/core/rrts_pkg.sv
// Shared widths, defaults and the queue entry layout of the round-robin scheduler.
package rrts_pkg;

   localparam int ID_W      = 8;
   localparam int BURST_W   = 16;
   localparam int TICK_W    = 32;
   localparam int QUANTUM_W = 8;

   localparam int QUEUE_DEPTH_DEF = 16;

   localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = 8'd2;

   // One queued job; due is arrival plus burst, so waiting time is one subtract
   typedef struct packed {
      logic [ID_W-1:0]    id;
      logic [TICK_W-1:0]  arrival;
      logic [TICK_W-1:0]  due;
      logic [BURST_W-1:0] remaining;
   } entry_type;

endpackage

>>> rtl/core/rrts_if.sv
// Channel interfaces of the round-robin scheduler: tick requests, results and quantum writes.
interface rrts_req_if;
   logic                         valid;
   logic                         ready;
   logic                         arrive;
   logic [rrts_pkg::ID_W-1:0]    process_id;
   logic [rrts_pkg::BURST_W-1:0] burst;

   modport source (output valid, output arrive, output process_id, output burst, input ready);
   modport sink   (input valid, input arrive, input process_id, input burst, output ready);
endinterface

interface rrts_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        running_valid;
   logic [rrts_pkg::ID_W-1:0]   running_id;
   logic                        done_res;
   logic [rrts_pkg::ID_W-1:0]   done_id;
   logic [rrts_pkg::TICK_W-1:0] completion_time;
   logic [rrts_pkg::TICK_W-1:0] turnaround;
   logic [rrts_pkg::TICK_W-1:0] waiting;
   logic                        dropped;

   modport source (output valid, output running_valid, output running_id, output done_res,
                   output done_id, output completion_time, output turnaround, output waiting,
                   output dropped, input ready);
   modport sink   (input valid, input running_valid, input running_id, input done_res,
                   input done_id, input completion_time, input turnaround, input waiting,
                   input dropped, output ready);
endinterface

interface rrts_csr_if;
   logic                           valid;
   logic                           ready;
   logic [rrts_pkg::QUANTUM_W-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/rrts_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rrts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write one word, read one word a cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/round_robin_time_slice_scheduler_top.sv
// Top level of the round-robin time-slice scheduler: ready queue in two RAM banks.
//
// Usage: every beat on req_chan is one time tick; it may carry a new job
// (arrive, process_id, burst). The job is queued at the tail, then the job at
// the head runs one unit. Each request beat yields exactly one rsp_chan beat
// that names the running job and, when it finishes, its completion,
// turnaround and waiting times; dropped flags an arrival refused by a full
// queue. csr_chan writes the quantum (ticks before the running job rotates to the
// tail); it is always ready, and the user must write it only while the block is
// idle, which the block itself does not enforce. The result is registered and shown
// in the cycle after its request is taken. Waiting jobs live in two RAM banks of
// even and odd slots, so the arrival and the rotated head reach the tail in the same
// cycle; the next head is prefetched from its bank, and an arrival that must become
// head at once is forwarded around the RAM. Reset clears the tick counter, slice
// counter, pointers and occupancy and sets the quantum to 2; no clearing pass is
// needed. One tick is taken every cycle while the receiver is ready; when it stalls,
// the result register holds and a new tick is taken only once it drains.
module round_robin_time_slice_scheduler_top #(
   parameter int QUEUE_DEPTH = rrts_pkg::QUEUE_DEPTH_DEF
) (
   input logic         clock,
   input logic         reset,
   rrts_req_if.sink    req_chan,
   rrts_rsp_if.source  rsp_chan,
   rrts_csr_if.sink    csr_chan
);

   localparam int PTR_W      = $clog2(QUEUE_DEPTH);
   localparam int BANK_DEPTH = 2 ** (PTR_W - 1);
   localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
   localparam int OCC_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int ENTRY_W    = $bits(rrts_pkg::entry_type);
   localparam int TICK_W     = rrts_pkg::TICK_W;
   localparam int QUANTUM_W  = rrts_pkg::QUANTUM_W;

   // state registers
   logic [OCC_W-1:0]       occ_ff, occ_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [TICK_W-1:0]      tick_ff, tick_in;
   logic [TICK_W-1:0]      tick_p1_ff, tick_p1_in;
   logic [QUANTUM_W-1:0]   slice_ff, slice_in;
   logic [QUANTUM_W-1:0]   quantum_ff, quantum_in;
   rrts_pkg::entry_type    hd_ff, hd_in;
   logic                   src_ram_ff, src_ram_in;
   logic                   rd_bank_ff;

   // result register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   run_ff, run_in;
   logic [rrts_pkg::ID_W-1:0] run_id_ff, run_id_in;
   logic                   fin_ff, fin_in;
   logic [rrts_pkg::ID_W-1:0] fin_id_ff, fin_id_in;
   logic [TICK_W-1:0]      ctime_ff, ctime_in;
   logic [TICK_W-1:0]      tat_ff, tat_in;
   logic [TICK_W-1:0]      wait_ff, wait_in;
   logic                   drop_ff, drop_in;

   // datapath
   logic                   accept;
   logic                   full;
   logic                   arr_ok;
   logic                   push_arr;
   logic                   run;
   logic                   fin;
   logic                   rot_due;
   logic                   wait_any;
   logic                   rot_push;
   logic                   pop;
   logic                   fwd_arr;
   logic [OCC_W-1:0]       occ1;
   logic [QUANTUM_W-1:0]   q_eff;
   logic [QUANTUM_W-1:0]   slice_inc;
   rrts_pkg::entry_type    arr_entry;
   rrts_pkg::entry_type    ram_entry;
   rrts_pkg::entry_type    head_cur;
   rrts_pkg::entry_type    head_upd;
   logic [PTR_W-1:0]       slot_a;
   logic [PTR_W-1:0]       slot_b;
   logic [ENTRY_W-1:0]     rd_data0, rd_data1;
   logic                   wr_en0, wr_en1;
   logic [BANK_AW-1:0]     wr_addr0, wr_addr1;
   logic [ENTRY_W-1:0]     wr_data0, wr_data1;
   logic [BANK_AW-1:0]     rd_addr;

   assign accept          = req_chan.valid && req_chan.ready;
   assign req_chan.ready  = !rsp_valid_ff || rsp_chan.ready;
   assign csr_chan.ready  = 1'b1;

   // build the arriving entry, stamped with the current tick
   always_comb begin
      arr_entry.id        = req_chan.process_id;
      arr_entry.arrival   = tick_ff;
      arr_entry.due       = tick_ff + TICK_W'(req_chan.burst);
      arr_entry.remaining = req_chan.burst;
   end

   assign ram_entry = rrts_pkg::entry_type'(rd_bank_ff ? rd_data1 : rd_data0);

   // enqueue the arrival, then pick the running job
   assign full     = (occ_ff == OCC_W'(QUEUE_DEPTH));
   assign arr_ok   = req_chan.arrive && !full;
   assign push_arr = arr_ok && (occ_ff != '0);
   assign occ1     = occ_ff + OCC_W'(arr_ok);
   assign run      = (occ1 != '0);
   assign wait_any = (occ1 > OCC_W'(1));

   always_comb begin
      if (occ_ff == '0) begin
         head_cur = arr_entry;
      end else if (src_ram_ff) begin
         head_cur = ram_entry;
      end else begin
         head_cur = hd_ff;
      end
      head_upd           = head_cur;
      head_upd.remaining = head_cur.remaining - rrts_pkg::BURST_W'(1);
   end

   // run one unit: finish, or count the slice and rotate at the quantum
   assign fin       = run && (head_cur.remaining <= rrts_pkg::BURST_W'(1));
   assign q_eff     = (quantum_ff == '0) ? QUANTUM_W'(1) : quantum_ff;
   assign slice_inc = slice_ff + QUANTUM_W'(1);
   assign rot_due   = run && !fin && (slice_inc >= q_eff);
   assign rot_push  = rot_due && wait_any;
   assign pop       = (fin || rot_due) && wait_any;
   assign fwd_arr   = pop && push_arr && (occ_ff == OCC_W'(1));

   // tail writes: arrival at slot_a, rotated head right after it (other bank) or at slot_a alone
   assign slot_a = wr_ptr_ff;
   assign slot_b = wr_ptr_ff + PTR_W'(push_arr);

   always_comb begin
      wr_en0   = 1'b0;
      wr_en1   = 1'b0;
      wr_addr0 = BANK_AW'(slot_a >> 1);
      wr_addr1 = BANK_AW'(slot_a >> 1);
      wr_data0 = arr_entry;
      wr_data1 = arr_entry;
      if (accept && push_arr) begin
         if (slot_a[0]) begin
            wr_en1 = 1'b1;
         end else begin
            wr_en0 = 1'b1;
         end
      end
      if (accept && rot_push) begin
         if (slot_b[0]) begin
            wr_en1   = 1'b1;
            wr_addr1 = BANK_AW'(slot_b >> 1);
            wr_data1 = head_upd;
         end else begin
            wr_en0   = 1'b1;
            wr_addr0 = BANK_AW'(slot_b >> 1);
            wr_data0 = head_upd;
         end
      end
   end

   // prefetch the first waiting job every cycle
   assign rd_addr = BANK_AW'(rd_ptr_ff >> 1);

   rrts_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (BANK_DEPTH)
   ) u_bank0 (
      .clock   (clock),
      .wr_en   (wr_en0),
      .wr_addr (wr_addr0),
      .wr_data (wr_data0),
      .rd_addr (rd_addr),
      .rd_data (rd_data0)
   );

   rrts_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (BANK_DEPTH)
   ) u_bank1 (
      .clock   (clock),
      .wr_en   (wr_en1),
      .wr_addr (wr_addr1),
      .wr_data (wr_data1),
      .rd_addr (rd_addr),
      .rd_data (rd_data1)
   );

   // next state
   always_comb begin
      occ_in       = occ_ff;
      rd_ptr_in    = rd_ptr_ff;
      wr_ptr_in    = wr_ptr_ff;
      tick_in      = tick_ff;
      tick_p1_in   = tick_p1_ff;
      slice_in     = slice_ff;
      quantum_in   = quantum_ff;
      hd_in        = hd_ff;
      src_ram_in   = src_ram_ff;
      rsp_valid_in = rsp_valid_ff;
      run_in       = run_ff;
      run_id_in    = run_id_ff;
      fin_in       = fin_ff;
      fin_id_in    = fin_id_ff;
      ctime_in     = ctime_ff;
      tat_in       = tat_ff;
      wait_in      = wait_ff;
      drop_in      = drop_ff;

      if (csr_chan.valid) begin
         quantum_in = csr_chan.data;
      end

      if (accept) begin
         occ_in     = occ1 - OCC_W'(fin);
         rd_ptr_in  = rd_ptr_ff + PTR_W'(pop);
         wr_ptr_in  = wr_ptr_ff + PTR_W'(push_arr) + PTR_W'(rot_push);
         tick_in    = tick_ff + TICK_W'(1);
         tick_p1_in = tick_p1_ff + TICK_W'(1);
         if (fin || rot_due) begin
            slice_in = '0;
         end else if (run) begin
            slice_in = slice_inc;
         end

         // advance the head, or keep the running job with its unit taken
         src_ram_in = 1'b0;
         if (pop) begin
            if (fwd_arr) begin
               hd_in = arr_entry;
            end else begin
               src_ram_in = 1'b1;
            end
         end else if (run && !fin) begin
            hd_in = head_upd;
         end

         rsp_valid_in = 1'b1;
         run_in       = run;
         run_id_in    = run ? head_cur.id : '0;
         fin_in       = fin;
         fin_id_in    = fin ? head_cur.id : '0;
         ctime_in     = fin ? tick_p1_ff : '0;
         tat_in       = fin ? (tick_p1_ff - head_cur.arrival) : '0;
         wait_in      = fin ? (tick_p1_ff - head_cur.due) : '0;
         drop_in      = req_chan.arrive && full;
      end else begin
         // hold the prefetched head before the read port moves on
         if (src_ram_ff) begin
            hd_in      = ram_entry;
            src_ram_in = 1'b0;
         end
         if (rsp_chan.ready) begin
            rsp_valid_in = 1'b0;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff       <= '0;
         rd_ptr_ff    <= '0;
         wr_ptr_ff    <= '0;
         tick_ff      <= '0;
         tick_p1_ff   <= TICK_W'(1);
         slice_ff     <= '0;
         quantum_ff   <= rrts_pkg::QUANTUM_RESET;
         src_ram_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         occ_ff       <= occ_in;
         rd_ptr_ff    <= rd_ptr_in;
         wr_ptr_ff    <= wr_ptr_in;
         tick_ff      <= tick_in;
         tick_p1_ff   <= tick_p1_in;
         slice_ff     <= slice_in;
         quantum_ff   <= quantum_in;
         src_ram_ff   <= src_ram_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      hd_ff      <= hd_in;
      rd_bank_ff <= rd_ptr_ff[0];
      run_ff     <= run_in;
      run_id_ff  <= run_id_in;
      fin_ff     <= fin_in;
      fin_id_ff  <= fin_id_in;
      ctime_ff   <= ctime_in;
      tat_ff     <= tat_in;
      wait_ff    <= wait_in;
      drop_ff    <= drop_in;
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.running_valid   = run_ff;
   assign rsp_chan.running_id      = run_id_ff;
   assign rsp_chan.done_res        = fin_ff;
   assign rsp_chan.done_id         = fin_id_ff;
   assign rsp_chan.completion_time = ctime_ff;
   assign rsp_chan.turnaround      = tat_ff;
   assign rsp_chan.waiting         = wait_ff;
   assign rsp_chan.dropped         = drop_ff;

endmodule

>>> rtl/core/rrts_checker.sv
// Port-level assertions for the round-robin scheduler, bound to its top level.
module rrts_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic                        rsp_running_valid,
   input logic [rrts_pkg::ID_W-1:0]   rsp_running_id,
   input logic                        rsp_done_res,
   input logic [rrts_pkg::ID_W-1:0]   rsp_done_id,
   input logic [rrts_pkg::TICK_W-1:0] rsp_completion_time
);

   // a stalled result beat stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_done_id)
         && $stable(rsp_completion_time))
      else $error("result beat changed while stalled");

   // each accepted tick shows a result on the next cycle
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("no result one cycle after an accepted tick");

   // a finished job is the job that ran
   a_done_runs: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> rsp_running_valid && (rsp_done_id == rsp_running_id))
      else $error("finished job differs from running job");

   // an idle tick reports nothing
   a_idle_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_running_valid |-> !rsp_done_res && (rsp_running_id == '0)
         && (rsp_completion_time == '0))
      else $error("idle tick carries job data");

endmodule

bind round_robin_time_slice_scheduler_top rrts_checker u_rrts_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_chan.valid),
   .req_ready           (req_chan.ready),
   .rsp_valid           (rsp_chan.valid),
   .rsp_ready           (rsp_chan.ready),
   .rsp_running_valid   (rsp_chan.running_valid),
   .rsp_running_id      (rsp_chan.running_id),
   .rsp_done_res        (rsp_chan.done_res),
   .rsp_done_id         (rsp_chan.done_id),
   .rsp_completion_time (rsp_chan.completion_time)
);
